// ----- hdl/vfsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and code tables for the vertex format string parser.
// Used by every module in the hdl folder; depends on nothing else.

package vfsp_pkg;

   // Character index saturation limit, min(text length limit - 1, 1023).
   localparam int unsigned MAX_TEXT_LEN = 1024;
   localparam logic [9:0]  IDX_CAP = (MAX_TEXT_LEN - 1 > 1023) ? 10'd1023
                                                               : 10'(MAX_TEXT_LEN - 1);

   // Limit on texture and color elements, capped so that the counts fit in five bits.
   localparam int unsigned MAX_REPEAT = 16;
   localparam logic [4:0]  REPEAT_CAP = (MAX_REPEAT > 31) ? 5'd31 : 5'(MAX_REPEAT);

   localparam logic [9:0]  STRIDE_CAP = 10'd1023;

   // Output queue depth.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Characters of the format language (upper case).
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // Element kinds.
   localparam logic [1:0] KIND_POSITION = 2'd0;
   localparam logic [1:0] KIND_NORMAL   = 2'd1;
   localparam logic [1:0] KIND_TEXTURE  = 2'd2;
   localparam logic [1:0] KIND_COLOR    = 2'd3;

   // Triangle types.
   localparam logic [1:0] PRIM_NONE  = 2'd0;
   localparam logic [1:0] PRIM_LIST  = 2'd1;
   localparam logic [1:0] PRIM_STRIP = 2'd2;

   // Status codes.
   localparam logic [4:0] ST_OK            = 5'd0;
   localparam logic [4:0] ST_EMPTY         = 5'd1;
   localparam logic [4:0] ST_UNEXPECTED_END = 5'd2;
   localparam logic [4:0] ST_STRUCTURE     = 5'd3;
   localparam logic [4:0] ST_TRI_TYPE      = 5'd4;
   localparam logic [4:0] ST_BAD_FIELD     = 5'd5;
   localparam logic [4:0] ST_POS_COUNT     = 5'd7;
   localparam logic [4:0] ST_POS_MANY      = 5'd8;
   localparam logic [4:0] ST_NRM_COUNT     = 5'd10;
   localparam logic [4:0] ST_NRM_MANY      = 5'd11;
   localparam logic [4:0] ST_COL_COUNT     = 5'd13;
   localparam logic [4:0] ST_COL_MANY      = 5'd14;
   localparam logic [4:0] ST_TEX_COUNT     = 5'd16;
   localparam logic [4:0] ST_TEX_MANY      = 5'd17;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_STRUCT = 3'd0,
      PH_TYPE   = 3'd1,
      PH_FIELD  = 3'd2,
      PH_DIGIT  = 3'd3,
      PH_DONE   = 3'd4,
      PH_ERROR  = 3'd5
   } phase_type;

   // Input word: one character.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_word_type;

   // Result word: element or final record.
   typedef struct packed {
      logic [1:0] field_kind;
      logic [9:0] byte_offset;
      logic [2:0] comp_count;
      logic [4:0] status;
      logic [1:0] tri_type;
      logic [9:0] stride_bytes;
      logic [9:0] error_index;
      logic       n_position;
      logic       n_normal;
      logic [4:0] n_texture;
      logic [4:0] n_color;
      logic       is_final;
   } rsp_word_type;

   // Records produced by one character, handed from parser to queue.
   typedef struct packed {
      logic         elem_valid;
      rsp_word_type elem;
      logic         fin_valid;
      rsp_word_type fin;
   } push_type;

   // Error code for a missing or bad component digit.
   function automatic logic [4:0] count_err(input logic [1:0] kind);
      logic [4:0] code;
      case (kind)
         KIND_POSITION: code = ST_POS_COUNT;
         KIND_NORMAL:   code = ST_NRM_COUNT;
         KIND_TEXTURE:  code = ST_TEX_COUNT;
         default:       code = ST_COL_COUNT;
      endcase
      return code;
   endfunction

   // Error code for too many elements of one kind.
   function automatic logic [4:0] many_err(input logic [1:0] kind);
      logic [4:0] code;
      case (kind)
         KIND_POSITION: code = ST_POS_MANY;
         KIND_NORMAL:   code = ST_NRM_MANY;
         KIND_TEXTURE:  code = ST_TEX_MANY;
         default:       code = ST_COL_MANY;
      endcase
      return code;
   endfunction

endpackage

// ----- hdl/vertex_format_string_parser.sv -----
`timescale 1ns / 1ps
// Top level of the vertex format string parser: parser plus output queue.
// Depends on vfsp_pkg, vfsp_parser and vfsp_out_queue.

// The parser takes one character per cycle while req_stall is low and updates its
// state in the cycle the word is accepted; the records that character causes land
// in a four-entry output queue and appear on the result port from the next cycle
// on, one word per cycle while rsp_stall is low. A character that closes a field
// and is also the last of the text yields two words, element first. req_stall is
// high whenever the queue has fewer than two free entries, which keeps a steady
// stream at one character per cycle as long as the result side keeps up.

module vertex_format_string_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vfsp_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vfsp_pkg::rsp_word_type rsp_word
);

   vfsp_pkg::push_type push;
   logic room;
   logic accept;

   // A character is taken only when both of its records are sure to fit.
   assign req_stall = !room;
   assign accept    = req_valid && room;

   vfsp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .push     (push)
   );

   vfsp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- hdl/vfsp_parser.sv -----
`timescale 1ns / 1ps
// Parser state and per-character decode: one character per accepted word.
// Depends on vfsp_pkg for types, character codes and status codes.

module vfsp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  vfsp_pkg::req_word_type req_word,
   output vfsp_pkg::push_type     push
);

   vfsp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  type_ff, type_in;
   logic [9:0]  stride_ff, stride_in;
   logic        cnt_pos_ff, cnt_pos_in;
   logic        cnt_nrm_ff, cnt_nrm_in;
   logic [4:0]  cnt_tex_ff, cnt_tex_in;
   logic [4:0]  cnt_col_ff, cnt_col_in;
   logic [1:0]  pending_kind_ff, pending_kind_in;
   logic [9:0]  token_index_ff, token_index_in;
   logic [9:0]  char_index_ff, char_index_in;
   logic [4:0]  error_code_ff, error_code_in;
   logic [9:0]  error_pos_ff, error_pos_in;

   logic [7:0]  ch;
   logic [7:0]  ch_up;
   logic        is_space;
   logic        is_digit;
   logic [2:0]  comps;
   logic [10:0] stride_sum;
   logic [9:0]  stride_sat;
   logic        at_limit;
   logic        elem_ok;
   logic [4:0]  fin_status;
   logic [9:0]  fin_eidx;

   // Character classes.
   assign ch       = req_word.ch;
   assign ch_up    = (ch >= vfsp_pkg::CH_LC_A && ch <= vfsp_pkg::CH_LC_Z)
                     ? ch - vfsp_pkg::CASE_GAP : ch;
   assign is_space = (ch == vfsp_pkg::CH_SPACE)
                     || (ch >= vfsp_pkg::CH_TAB && ch <= vfsp_pkg::CH_CR);
   assign is_digit = (ch >= vfsp_pkg::CH_ONE) && (ch <= vfsp_pkg::CH_FOUR);
   assign comps    = ch[2:0];

   // Stride update, saturating at the cap.
   assign stride_sum = {1'b0, stride_ff} + {6'd0, comps, 2'b00};
   assign stride_sat = stride_sum[10] ? vfsp_pkg::STRIDE_CAP : stride_sum[9:0];

   // Has the pending kind reached its element limit?
   always_comb begin
      case (pending_kind_ff)
         vfsp_pkg::KIND_POSITION: at_limit = cnt_pos_ff;
         vfsp_pkg::KIND_NORMAL:   at_limit = cnt_nrm_ff;
         vfsp_pkg::KIND_TEXTURE:  at_limit = (cnt_tex_ff >= vfsp_pkg::REPEAT_CAP);
         default:                 at_limit = (cnt_col_ff >= vfsp_pkg::REPEAT_CAP);
      endcase
   end

   // Next state for the current character.
   always_comb begin
      phase_in        = phase_ff;
      type_in         = type_ff;
      stride_in       = stride_ff;
      cnt_pos_in      = cnt_pos_ff;
      cnt_nrm_in      = cnt_nrm_ff;
      cnt_tex_in      = cnt_tex_ff;
      cnt_col_in      = cnt_col_ff;
      pending_kind_in = pending_kind_ff;
      token_index_in  = token_index_ff;
      error_code_in   = error_code_ff;
      error_pos_in    = error_pos_ff;
      elem_ok         = 1'b0;
      case (phase_ff)
         vfsp_pkg::PH_STRUCT: begin
            if (!is_space) begin
               if (ch_up == vfsp_pkg::CH_I) begin
                  phase_in = vfsp_pkg::PH_TYPE;
               end else begin
                  phase_in      = vfsp_pkg::PH_ERROR;
                  error_code_in = vfsp_pkg::ST_STRUCTURE;
                  error_pos_in  = char_index_ff;
               end
            end
         end
         vfsp_pkg::PH_TYPE: begin
            if (!is_space) begin
               if (ch_up == vfsp_pkg::CH_L) begin
                  type_in  = vfsp_pkg::PRIM_LIST;
                  phase_in = vfsp_pkg::PH_FIELD;
               end else if (ch_up == vfsp_pkg::CH_S) begin
                  type_in  = vfsp_pkg::PRIM_STRIP;
                  phase_in = vfsp_pkg::PH_FIELD;
               end else begin
                  phase_in      = vfsp_pkg::PH_ERROR;
                  error_code_in = vfsp_pkg::ST_TRI_TYPE;
                  error_pos_in  = char_index_ff;
               end
            end
         end
         vfsp_pkg::PH_FIELD: begin
            if (!is_space) begin
               token_index_in = char_index_ff;
               phase_in       = vfsp_pkg::PH_DIGIT;
               if (ch_up == vfsp_pkg::CH_HASH) begin
                  token_index_in = token_index_ff;
                  phase_in       = vfsp_pkg::PH_DONE;
               end else if (ch_up == vfsp_pkg::CH_P) begin
                  pending_kind_in = vfsp_pkg::KIND_POSITION;
               end else if (ch_up == vfsp_pkg::CH_N) begin
                  pending_kind_in = vfsp_pkg::KIND_NORMAL;
               end else if (ch_up == vfsp_pkg::CH_T) begin
                  pending_kind_in = vfsp_pkg::KIND_TEXTURE;
               end else if (ch_up == vfsp_pkg::CH_C) begin
                  pending_kind_in = vfsp_pkg::KIND_COLOR;
               end else begin
                  token_index_in = token_index_ff;
                  phase_in       = vfsp_pkg::PH_ERROR;
                  error_code_in  = vfsp_pkg::ST_BAD_FIELD;
                  error_pos_in   = char_index_ff;
               end
            end
         end
         vfsp_pkg::PH_DIGIT: begin
            if (!is_digit) begin
               phase_in      = vfsp_pkg::PH_ERROR;
               error_code_in = vfsp_pkg::count_err(pending_kind_ff);
               error_pos_in  = token_index_ff;
            end else if (at_limit) begin
               phase_in      = vfsp_pkg::PH_ERROR;
               error_code_in = vfsp_pkg::many_err(pending_kind_ff);
               error_pos_in  = token_index_ff;
            end else begin
               elem_ok   = 1'b1;
               phase_in  = vfsp_pkg::PH_FIELD;
               stride_in = stride_sat;
               case (pending_kind_ff)
                  vfsp_pkg::KIND_POSITION: cnt_pos_in = 1'b1;
                  vfsp_pkg::KIND_NORMAL:   cnt_nrm_in = 1'b1;
                  vfsp_pkg::KIND_TEXTURE:  cnt_tex_in = cnt_tex_ff + 5'd1;
                  default:                 cnt_col_in = cnt_col_ff + 5'd1;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Character index, saturating.
   assign char_index_in = (char_index_ff < vfsp_pkg::IDX_CAP) ? char_index_ff + 10'd1
                                                               : vfsp_pkg::IDX_CAP;

   // Final status from the phase this character leaves behind.
   always_comb begin
      fin_status = vfsp_pkg::ST_OK;
      fin_eidx   = 10'd0;
      case (phase_in)
         vfsp_pkg::PH_STRUCT: begin
            fin_status = vfsp_pkg::ST_EMPTY;
            fin_eidx   = char_index_in;
         end
         vfsp_pkg::PH_TYPE: begin
            fin_status = vfsp_pkg::ST_UNEXPECTED_END;
            fin_eidx   = char_index_in;
         end
         vfsp_pkg::PH_DIGIT: begin
            fin_status = vfsp_pkg::ST_UNEXPECTED_END;
            fin_eidx   = token_index_in;
         end
         vfsp_pkg::PH_ERROR: begin
            fin_status = error_code_in;
            fin_eidx   = error_pos_in;
         end
         default: begin
         end
      endcase
   end

   // Element record, then the final record; on error the final record carries
   // nothing but status and index.
   always_comb begin
      push.elem_valid        = accept && elem_ok;
      push.elem.field_kind   = pending_kind_ff;
      push.elem.byte_offset  = stride_ff;
      push.elem.comp_count   = comps;
      push.elem.status       = vfsp_pkg::ST_OK;
      push.elem.tri_type     = type_ff;
      push.elem.stride_bytes = stride_in;
      push.elem.error_index  = 10'd0;
      push.elem.n_position   = cnt_pos_in;
      push.elem.n_normal     = cnt_nrm_in;
      push.elem.n_texture    = cnt_tex_in;
      push.elem.n_color      = cnt_col_in;
      push.elem.is_final     = 1'b0;

      push.fin_valid        = accept && req_word.last;
      push.fin.field_kind   = vfsp_pkg::KIND_POSITION;
      push.fin.byte_offset  = 10'd0;
      push.fin.comp_count   = 3'd0;
      push.fin.status       = fin_status;
      push.fin.error_index  = fin_eidx;
      push.fin.is_final     = 1'b1;
      if (fin_status != vfsp_pkg::ST_OK) begin
         push.fin.tri_type     = vfsp_pkg::PRIM_NONE;
         push.fin.stride_bytes = 10'd0;
         push.fin.n_position   = 1'b0;
         push.fin.n_normal     = 1'b0;
         push.fin.n_texture    = 5'd0;
         push.fin.n_color      = 5'd0;
      end else begin
         push.fin.tri_type     = type_in;
         push.fin.stride_bytes = stride_in;
         push.fin.n_position   = cnt_pos_in;
         push.fin.n_normal     = cnt_nrm_in;
         push.fin.n_texture    = cnt_tex_in;
         push.fin.n_color      = cnt_col_in;
      end
   end

   // State registers; the last character of a text starts the parser over.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_word.last)) begin
         phase_ff        <= vfsp_pkg::PH_STRUCT;
         type_ff         <= vfsp_pkg::PRIM_NONE;
         stride_ff       <= 10'd0;
         cnt_pos_ff      <= 1'b0;
         cnt_nrm_ff      <= 1'b0;
         cnt_tex_ff      <= 5'd0;
         cnt_col_ff      <= 5'd0;
         pending_kind_ff <= vfsp_pkg::KIND_POSITION;
         token_index_ff  <= 10'd0;
         char_index_ff   <= 10'd0;
         error_code_ff   <= vfsp_pkg::ST_OK;
         error_pos_ff    <= 10'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         type_ff         <= type_in;
         stride_ff       <= stride_in;
         cnt_pos_ff      <= cnt_pos_in;
         cnt_nrm_ff      <= cnt_nrm_in;
         cnt_tex_ff      <= cnt_tex_in;
         cnt_col_ff      <= cnt_col_in;
         pending_kind_ff <= pending_kind_in;
         token_index_ff  <= token_index_in;
         char_index_ff   <= char_index_in;
         error_code_ff   <= error_code_in;
         error_pos_ff    <= error_pos_in;
      end
   end

endmodule

// ----- hdl/vfsp_out_queue.sv -----
`timescale 1ns / 1ps
// Output queue: takes up to two records a cycle, hands out one word a cycle unless rsp_stall is high.
// Depends on vfsp_pkg for the record types and queue sizing.

module vfsp_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  vfsp_pkg::push_type     push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vfsp_pkg::rsp_word_type rsp_word
);

   vfsp_pkg::rsp_word_type entry_ff [vfsp_pkg::QUEUE_DEPTH];
   logic [vfsp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vfsp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vfsp_pkg::QCNT_W-1:0] count_ff, count_in;

   vfsp_pkg::rsp_word_type first_word;
   logic [1:0] n_push;
   logic       pop;

   // Element record goes ahead of the final record.
   assign first_word = push.elem_valid ? push.elem : push.fin;
   assign n_push     = {1'b0, push.elem_valid} + {1'b0, push.fin_valid};
   assign pop        = rsp_valid && !rsp_stall;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= vfsp_pkg::QCNT_W'(vfsp_pkg::QUEUE_DEPTH - 2));

   // Pointer and fill count arithmetic.
   assign wr_ptr_in = wr_ptr_ff + vfsp_pkg::QPTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + vfsp_pkg::QPTR_W'(pop);
   assign count_in  = count_ff + vfsp_pkg::QCNT_W'(n_push) - vfsp_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first_word;
      end
      if (push.elem_valid && push.fin_valid) begin
         entry_ff[wr_ptr_ff + vfsp_pkg::QPTR_W'(1)] <= push.fin;
      end
   end

endmodule

// ----- hdl/vfsp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the vertex format string parser, bound to the top level.
// Depends on vfsp_pkg and on the ports of vertex_format_string_parser.

module vfsp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vfsp_pkg::rsp_word_type rsp_word
);

   // Nothing is offered in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // Element records carry a component count of one to four and no status.
   a_elem_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.is_final |->
         rsp_word.status == vfsp_pkg::ST_OK && rsp_word.comp_count != 3'd0
         && rsp_word.comp_count <= 3'd4 && rsp_word.error_index == 10'd0)
      else $error("malformed element record");

   // A failed text reports no triangle type, stride, texture count or color count.
   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_final && rsp_word.status != vfsp_pkg::ST_OK |->
         rsp_word.tri_type == vfsp_pkg::PRIM_NONE && rsp_word.stride_bytes == 10'd0
         && rsp_word.n_texture == 5'd0 && rsp_word.n_color == 5'd0)
      else $error("error record carries payload");

   // A successful final record names a triangle type and has a component count of zero.
   a_ok_has_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_final && rsp_word.status == vfsp_pkg::ST_OK |->
         rsp_word.tri_type != vfsp_pkg::PRIM_NONE && rsp_word.comp_count == 3'd0)
      else $error("successful final record without triangle type");

endmodule

bind vertex_format_string_parser vfsp_checker u_vfsp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
